[rtl/cftl_pkg.sv]
// cftl_pkg: shared widths, reset values, register indexes and sequencer
// states of the capture frequency to level block. No dependencies.
`default_nettype none

package cftl_pkg;

    // Field widths
    localparam int CAPTURE_W  = 32;
    localparam int FREQ_W     = 31;
    localparam int LEVEL_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Shared divider operand widths: clock rate or offset*span as numerator
    localparam int DIV_NUM_W = FREQ_W + LEVEL_W;
    localparam int DIV_DEN_W = CAPTURE_W;

    // Register reset values
    localparam logic [FREQ_W-1:0]  CLOCK_HZ_RST = FREQ_W'(16000000);
    localparam logic [FREQ_W-1:0]  IN_LOW_RST   = '0;
    localparam logic [FREQ_W-1:0]  IN_HIGH_RST  = FREQ_W'(510);
    localparam logic [LEVEL_W-1:0] OUT_LOW_RST  = '0;
    localparam logic [LEVEL_W-1:0] OUT_HIGH_RST = LEVEL_W'(4095);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH = 3'd4;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FREQ = 5'b00010,
        ST_MAP  = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

`default_nettype wire

[rtl/cftl_div.sv]
// cftl_div: restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; widths come from the parameters.
`default_nettype none

module cftl_div #(
    parameter int NUM_W = 43,
    parameter int DEN_W = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numerator,
    input  wire logic [DEN_W-1:0] denominator,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   trial;
    logic             fits;

    // One restoring step: shift in the next numerator bit, try a subtract
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign trial     = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = numerator;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? trial[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= denominator;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/capture_frequency_to_level.sv]
// capture_frequency_to_level: period, frequency and mapped level from edge
// timestamps. Depends on cftl_pkg and cftl_div.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   input    | in_valid / in_stall   | capture_time
//   output   | out_valid / out_stall | period, frequency, level, period_zero
//   config   | cfg_write             | cfg_index, cfg_data
//
// One request takes a 43-step divide for the frequency, a clamp/multiply
// step in ST_MAP and a second 43-step divide for the scaling, all on the
// single shared serial divider. Clamped cases and an empty input band skip
// the second divide; a zero period skips both. in_stall is high while a
// request is in work; a finished result sits in the output register until
// taken, so the next request is accepted meanwhile. Reset restores the
// register defaults and clears the previous timestamp.
`default_nettype none

module capture_frequency_to_level (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [cftl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cftl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [cftl_pkg::CAPTURE_W-1:0]   capture_time,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [cftl_pkg::CAPTURE_W-1:0]   period,
    output logic      [cftl_pkg::FREQ_W-1:0]      frequency,
    output logic      [cftl_pkg::LEVEL_W-1:0]     level,
    output logic                                  period_zero
);

    import cftl_pkg::*;

    // Configuration registers
    logic [FREQ_W-1:0]    clock_hz_reg;
    logic [FREQ_W-1:0]    in_low_reg;
    logic [FREQ_W-1:0]    in_high_reg;
    logic [LEVEL_W-1:0]   out_low_reg;
    logic [LEVEL_W-1:0]   out_high_reg;

    // Sequencer and working registers
    state_t               state_reg, state_next;
    logic [CAPTURE_W-1:0] last_capture_reg;
    logic [CAPTURE_W-1:0] period_reg;
    logic                 zero_reg;
    logic [FREQ_W-1:0]    freq_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic                 neg_reg;

    // Output register
    logic                 out_valid_reg;
    logic [CAPTURE_W-1:0] out_period_reg;
    logic [FREQ_W-1:0]    out_freq_reg;
    logic [LEVEL_W-1:0]   out_level_reg;
    logic                 out_zero_reg;

    logic                 in_accept;
    logic                 out_take;
    logic                 out_load;
    logic [CAPTURE_W-1:0] period_now;

    logic                 below;
    logic                 above;
    logic                 map_divide;
    logic [FREQ_W-1:0]    offset;
    logic [FREQ_W-1:0]    span_in;
    logic [LEVEL_W-1:0]   span_out;
    logic [DIV_NUM_W-1:0] product;
    logic [LEVEL_W-1:0]   quo_level;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    // Handshakes
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_take   = out_valid_reg && !out_stall;
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign period_now = capture_time - last_capture_reg;

    // Clamp tests and scaling product
    assign below      = (freq_reg < in_low_reg);
    assign above      = (freq_reg > in_high_reg);
    assign map_divide = !below && !above && (in_high_reg != in_low_reg);
    assign offset     = freq_reg - in_low_reg;
    assign span_in    = in_high_reg - in_low_reg;
    assign span_out   = (out_high_reg < out_low_reg) ? (out_low_reg - out_high_reg)
                                                     : (out_high_reg - out_low_reg);
    assign product    = DIV_NUM_W'(offset) * DIV_NUM_W'(span_out);
    assign quo_level  = div_quo[LEVEL_W-1:0];

    // Divider operand select: frequency first, then scaling
    always_comb
    begin
        div_start = 1'b0;
        div_num   = DIV_NUM_W'(clock_hz_reg);
        div_den   = period_now;
        if ((state_reg == ST_IDLE) && in_accept && (period_now != '0))
        begin
            div_start = 1'b1;
        end
        else if ((state_reg == ST_MAP) && map_divide)
        begin
            div_start = 1'b1;
            div_num   = product;
            div_den   = DIV_DEN_W'(span_in);
        end
    end

    cftl_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .numerator   (div_num),
        .denominator (div_den),
        .done        (div_done),
        .quotient    (div_quo)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (period_now == '0) ? ST_DONE : ST_FREQ;
                end
            end
            ST_FREQ:
            begin
                if (div_done)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                state_next = map_divide ? ST_SCALE : ST_DONE;
            end
            ST_SCALE:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            last_capture_reg <= '0;
            out_valid_reg    <= 1'b0;
            clock_hz_reg     <= CLOCK_HZ_RST;
            in_low_reg       <= IN_LOW_RST;
            in_high_reg      <= IN_HIGH_RST;
            out_low_reg      <= OUT_LOW_RST;
            out_high_reg     <= OUT_HIGH_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                last_capture_reg <= capture_time;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_CLOCK_HZ: clock_hz_reg <= cfg_data[FREQ_W-1:0];
                    REG_IN_LOW:   in_low_reg   <= cfg_data[FREQ_W-1:0];
                    REG_IN_HIGH:  in_high_reg  <= cfg_data[FREQ_W-1:0];
                    REG_OUT_LOW:  out_low_reg  <= cfg_data[LEVEL_W-1:0];
                    REG_OUT_HIGH: out_high_reg <= cfg_data[LEVEL_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // Working datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    period_reg <= period_now;
                    zero_reg   <= (period_now == '0);
                    freq_reg   <= '0;
                    level_reg  <= out_low_reg;
                end
            end
            ST_FREQ:
            begin
                if (div_done)
                begin
                    freq_reg <= div_quo[FREQ_W-1:0];
                end
            end
            ST_MAP:
            begin
                neg_reg <= (out_high_reg < out_low_reg);
                if (below)
                begin
                    level_reg <= out_low_reg;
                end
                else if (above)
                begin
                    level_reg <= out_high_reg;
                end
                else
                begin
                    level_reg <= out_low_reg;
                end
            end
            ST_SCALE:
            begin
                if (div_done)
                begin
                    level_reg <= neg_reg ? (out_low_reg - quo_level)
                                         : (out_low_reg + quo_level);
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_period_reg <= period_reg;
            out_freq_reg   <= freq_reg;
            out_level_reg  <= level_reg;
            out_zero_reg   <= zero_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign period      = out_period_reg;
    assign frequency   = out_freq_reg;
    assign level       = out_level_reg;
    assign period_zero = out_zero_reg;

endmodule

`default_nettype wire

[tb/cftl_reading_checker.sv]
// cftl_reading_checker: watches the config, request and result channels of
// capture_frequency_to_level, predicts each reading and compares it.
// Depends on cftl_pkg.
`default_nettype none

module cftl_reading_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [cftl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cftl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic [cftl_pkg::CAPTURE_W-1:0]  capture_time,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [cftl_pkg::CAPTURE_W-1:0]  period,
    input  wire logic [cftl_pkg::FREQ_W-1:0]     frequency,
    input  wire logic [cftl_pkg::LEVEL_W-1:0]    level,
    input  wire logic                            period_zero,
    output int                                   errors,
    output int                                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import cftl_pkg::*;

    typedef struct packed {
        logic [CAPTURE_W-1:0] period;
        logic [FREQ_W-1:0]    frequency;
        logic [LEVEL_W-1:0]   level;
        logic                 period_zero;
    } reading_t;

    // Local copy of the register file and the previous timestamp
    logic [FREQ_W-1:0]    rate_hz    = CLOCK_HZ_RST;
    logic [FREQ_W-1:0]    band_lo    = IN_LOW_RST;
    logic [FREQ_W-1:0]    band_hi    = IN_HIGH_RST;
    logic [LEVEL_W-1:0]   lvl_lo     = OUT_LOW_RST;
    logic [LEVEL_W-1:0]   lvl_hi     = OUT_HIGH_RST;
    logic [CAPTURE_W-1:0] last_stamp = '0;

    reading_t readings_due[$];
    int       mismatch_count = 0;
    int       due_count      = 0;

    assign errors      = mismatch_count;
    assign outstanding = due_count;

    // Clamp, then linear map with a signed 64-bit product, truncating quotient
    function automatic logic [LEVEL_W-1:0] scale_level(input logic [FREQ_W-1:0] f);
        longint lo;
        longint hi;
        longint olo;
        longint ohi;
        longint offset;
        lo     = longint'(band_lo);
        hi     = longint'(band_hi);
        olo    = longint'(lvl_lo);
        ohi    = longint'(lvl_hi);
        offset = longint'(f);
        if (f < band_lo)
            return lvl_lo;
        if (f > band_hi)
            return lvl_hi;
        if (band_hi == band_lo)
            return lvl_lo;
        return LEVEL_W'((offset - lo) * (ohi - olo) / (hi - lo) + olo);
    endfunction

    function automatic reading_t predict_reading(input logic [CAPTURE_W-1:0] delta);
        reading_t r;
        r.period = delta;
        if (delta == '0)
        begin
            r.frequency   = '0;
            r.level       = lvl_lo;
            r.period_zero = 1'b1;
        end
        else
        begin
            r.frequency   = FREQ_W'(rate_hz / delta);
            r.level       = scale_level(r.frequency);
            r.period_zero = 1'b0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Track config writes, queue a prediction per request, compare per result
    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            rate_hz    = CLOCK_HZ_RST;
            band_lo    = IN_LOW_RST;
            band_hi    = IN_HIGH_RST;
            lvl_lo     = OUT_LOW_RST;
            lvl_hi     = OUT_HIGH_RST;
            last_stamp = '0;
            readings_due.delete();
            due_count <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_CLOCK_HZ: rate_hz = cfg_data[FREQ_W-1:0];
                    REG_IN_LOW:   band_lo = cfg_data[FREQ_W-1:0];
                    REG_IN_HIGH:  band_hi = cfg_data[FREQ_W-1:0];
                    REG_OUT_LOW:  lvl_lo  = cfg_data[LEVEL_W-1:0];
                    REG_OUT_HIGH: lvl_hi  = cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                readings_due.push_back(predict_reading(capture_time - last_stamp));
                last_stamp = capture_time;
            end

            if (out_valid && !out_stall)
            begin
                if (readings_due.size() == 0)
                begin
                    $error("result with no request outstanding: period %0d", period);
                    mismatch_count++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    check_field("period", 64'(want.period), 64'(period));
                    check_field("frequency", 64'(want.frequency), 64'(frequency));
                    check_field("level", 64'(want.level), 64'(level));
                    check_field("period_zero", 64'(want.period_zero), 64'(period_zero));
                end
            end

            due_count <= readings_due.size();
        end
    end

endmodule

`default_nettype wire

[tb/tb_capture_frequency_to_level.sv]
// tb_capture_frequency_to_level: clock, reset, config writes, request and
// result handshakes with random idling, and the verdict. Depends on cftl_pkg,
// capture_frequency_to_level and cftl_reading_checker.
`default_nettype none

module tb_capture_frequency_to_level;
    timeunit 1ns;
    timeprecision 1ps;

    import cftl_pkg::*;

    localparam int     HALF_PERIOD     = 10;
    localparam int     RESET_CYCLES    = 5;
    localparam int     RANDOM_PHASES   = 10;
    localparam int     ITEMS_PER_PHASE = 95;
    localparam int     NO_GAP_PHASE    = 3;
    localparam int     HOLD_PHASE      = 5;
    localparam int     LONG_HOLD       = 600;
    localparam int     SETTLE_CYCLES   = 120;
    localparam longint CYCLE_LIMIT     = 3_000_000;

    // Index with no register behind it; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = REG_CLOCK_HZ;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    wire                   in_stall;
    logic [CAPTURE_W-1:0]  capture_time = '0;
    wire                   out_valid;
    logic                  out_stall    = 1'b0;
    wire  [CAPTURE_W-1:0]  period;
    wire  [FREQ_W-1:0]     frequency;
    wire  [LEVEL_W-1:0]    level;
    wire                   period_zero;
    int                    errors;
    int                    outstanding;

    logic                  no_gaps      = 1'b0;
    logic                  hold_request = 1'b0;
    logic [CAPTURE_W-1:0]  stamp        = '0;
    longint                rate_now     = longint'(CLOCK_HZ_RST);
    longint                lo_now       = longint'(IN_LOW_RST);
    longint                hi_now       = longint'(IN_HIGH_RST);
    longint                cycles       = 0;

    capture_frequency_to_level DUT (.*);

    cftl_reading_checker reading_check (.*);

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_capture_frequency_to_level: done, errors");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // Called at a clock edge; returns at the edge where the request is taken
    task automatic send_capture(input logic [CAPTURE_W-1:0] t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        capture_time <= t;
        stamp = t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_delta(input logic [CAPTURE_W-1:0] d);
        send_capture(stamp + d);
    endtask

    // Drop valid and wait until every reading has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Write all five registers back to back while idle, then the spare index if asked
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] hz, lo, hi, olo, ohi,
                                  input bit poke_spare);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= REG_CLOCK_HZ;
        cfg_data  <= hz;
        @(posedge clk);
        cfg_index <= REG_IN_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_IN_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= REG_OUT_LOW;
        cfg_data  <= olo;
        @(posedge clk);
        cfg_index <= REG_OUT_HIGH;
        cfg_data  <= ohi;
        @(posedge clk);
        if (poke_spare)
        begin
            cfg_index <= REG_SPARE;
            cfg_data  <= CFG_DATA_W'($urandom);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        rate_now = longint'(hz);
        lo_now   = longint'(lo);
        hi_now   = longint'(hi);
        @(posedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                n = LONG_HOLD;
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                    out_stall <= 1'b1;
                else
                begin
                    out_stall <= 1'b0;
                    n = $urandom_range(1, 6);
                end
            end
            repeat (n) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] hz;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] olo;
        logic [CFG_DATA_W-1:0] ohi;
        logic [CFG_DATA_W-1:0] tmp;
        int unsigned           r;
        int unsigned           f;
        longint                band_min;
        longint                band_max;
        longint                p;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero periods, wrap-around, the upper clamp, band edges
        send_capture('0);
        send_capture('1);
        send_capture('0);
        send_capture('0);
        send_delta(31373);
        send_delta(31372);
        send_delta(31300);
        send_delta(62745);
        send_delta(32'h8000_0000);
        send_capture(32'h5555_5555);
        send_capture(32'hAAAA_AAAA);

        // Widest clock and band: largest product in the scaling
        apply_settings('1, '0, '1, 31'd0, 31'd4095, 1'b0);
        send_delta(1);
        send_delta(2);
        send_delta(3);

        // Zero clock rate, plus a write to an unused index
        apply_settings('0, 31'd100, 31'd200, 31'd7, 31'd3000, 1'b1);
        send_delta(5);
        send_delta(0);

        // Empty band: frequency equal to both ends, just above, just below
        apply_settings(31'd16000, 31'd1000, 31'd1000, 31'd100, 31'd3000, 1'b0);
        send_delta(16);
        send_delta(15);
        send_delta(17);

        // Reversed band; output levels written with junk above bit 11
        apply_settings(31'd1000000, 31'd2000, 31'd1000, 31'h5A5A_5FFF, 31'h2A5A_5000,
                       1'b0);
        send_delta(400);
        send_delta(1000);
        send_delta(666);

        // Falling output range: negative quotient truncates toward zero
        apply_settings(31'd1000000, 31'd100, 31'd5000, 31'd4000, 31'd5, 1'b0);
        send_delta(1000);
        send_delta(300);
        send_delta(7000);

        // Random phases, each under its own settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                hz  = CLOCK_HZ_RST;
                lo  = IN_LOW_RST;
                hi  = IN_HIGH_RST;
                olo = CFG_DATA_W'(OUT_LOW_RST);
                ohi = CFG_DATA_W'(OUT_HIGH_RST);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       hz = CFG_DATA_W'($urandom_range(1, 5000));
                    1:       hz = CFG_DATA_W'($urandom_range(5000, 50_000_000));
                    2:       hz = CFG_DATA_W'($urandom);
                    default: hz = '1;
                endcase
                hi = CFG_DATA_W'($urandom_range(0, hz));
                lo = CFG_DATA_W'($urandom_range(0, hi));
                r  = $urandom_range(0, 9);
                if (r == 0)
                begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                else if (r == 1)
                    lo = hi;
                olo = $urandom_range(0, 1) ? CFG_DATA_W'($urandom)
                                           : CFG_DATA_W'($urandom_range(0, 4095));
                ohi = $urandom_range(0, 1) ? CFG_DATA_W'($urandom)
                                           : CFG_DATA_W'($urandom_range(0, 4095));
            end
            apply_settings(hz, lo, hi, olo, ohi, 1'b0);
            no_gaps = (ph == NO_GAP_PHASE);
            if (ph == HOLD_PHASE)
                hold_request = 1'b1;

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    // Period aimed at a frequency in or near the band
                    band_min = (lo_now < hi_now) ? lo_now : hi_now;
                    band_max = (lo_now < hi_now) ? hi_now : lo_now;
                    f = $urandom_range(32'(band_max + band_max / 8 + 2), 32'(band_min / 2));
                    p = (f == 0) ? 1 : rate_now / f;
                    p = p + longint'($urandom_range(0, 2)) - 1;
                    if (p < 1)
                        p = 1;
                    send_delta(CAPTURE_W'(p));
                end
                else if (r < 73)
                    send_delta(0);
                else if (r < 83)
                    send_delta($urandom_range(1, 16));
                else
                    send_capture($urandom);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_capture_frequency_to_level: done, clean");
        else
            $display("tb_capture_frequency_to_level: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
